[hdl/apq_pkg.sv]
// Shared constants and types for the array priority queue.
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ITEM_W_DEF  = 32;
  localparam int unsigned PRI_W_DEF   = 16;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

`default_nettype wire

[hdl/apq_scan.sv]
// Running maximum compare unit: tracks the earliest entry with the highest priority.
`timescale 1ns / 1ps
`default_nettype none

module apq_scan #(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned ITEM_W = apq_pkg::ITEM_W_DEF,
  parameter int unsigned PRI_W  = apq_pkg::PRI_W_DEF
) (
  input  wire logic              clk_i,
  input  wire apq_pkg::scan_ctl_t ctl_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [PRI_W-1:0]  pri_i,
  input  wire logic [ITEM_W-1:0] item_i,
  output logic      [IDX_W-1:0]  best_idx_o,
  output logic      [ITEM_W-1:0] best_item_o
);

  logic [PRI_W-1:0]  best_pri_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [ITEM_W-1:0] best_item_q;
  logic              take;

  // strict compare keeps the earliest entry on a tie
  assign take = ctl_i.valid && (ctl_i.first || (pri_i > best_pri_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_pri_q  <= pri_i;
      best_idx_q  <= idx_i;
      best_item_q <= item_i;
    end
  end

  assign best_idx_o  = best_idx_q;
  assign best_item_o = best_item_q;

endmodule

`default_nettype wire

[hdl/array_priority_queue_max_core.sv]
// Top level of the bounded max priority queue held as an insertion-ordered array.
//
// Usage: drive operation_i, item_value_i and priority_req_i and raise start
// while busy is low; the item is taken at that clock edge. Operations are
// add (append, or drop with status full), extract (return the earliest
// entry of highest priority and close the gap) and clear.
// One result per item appears on the result ports for exactly one cycle,
// marked by done_o, together with the count and full/empty flags after the
// operation. The receiver cannot stall; results must be taken when shown.
// Add, clear, unused codes and extract on an empty queue give their result
// in the cycle after acceptance, and busy stays low, so such items can be
// issued every cycle.
// Extract: a scan reads every entry through the single read port into the
// shared compare unit, a pick step takes the winner, then a tail shift moves
// each entry after the served position down by one, followed by a drain step
// when any entry moved and a finish step, with done_o in the cycle after.
// Reset clears the count and the control state; entry storage is not
// cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module array_priority_queue_max_core #(
  parameter int unsigned DEPTH          = apq_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_WIDTH     = apq_pkg::ITEM_W_DEF,
  parameter int unsigned PRIORITY_WIDTH = apq_pkg::PRI_W_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                operation_i,
  input  wire logic [ITEM_WIDTH-1:0]     item_value_i,
  input  wire logic [PRIORITY_WIDTH-1:0] priority_req_i,
  output logic                           done_o,
  output logic      [ITEM_WIDTH-1:0]     item_out_o,
  output logic      [1:0]                status_o,
  output logic      [CNT_W-1:0]          count_o,
  output logic                           is_full_o,
  output logic                           is_empty_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PICK  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_e;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic                      done_q, done_d;
  logic [ITEM_WIDTH-1:0]     item_out_q, item_out_d;
  logic [1:0]                status_q, status_d;
  logic                      rvalid_q;
  logic [IDX_W-1:0]          ridx_q;
  logic                      pend_q;
  logic [IDX_W-1:0]          pend_addr_q;

  logic [ITEM_WIDTH-1:0]     item_mem [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri_mem  [DEPTH];
  logic [ITEM_WIDTH-1:0]     item_rd_q;
  logic [PRIORITY_WIDTH-1:0] pri_rd_q;

  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [ITEM_WIDTH-1:0]     wr_item;
  logic [PRIORITY_WIDTH-1:0] wr_pri;
  logic                      accept;

  apq_pkg::scan_ctl_t        scan_ctl;
  logic [IDX_W-1:0]          best_idx;
  logic [ITEM_WIDTH-1:0]     best_item;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    done_d     = 1'b0;
    item_out_d = item_out_q;
    status_d   = status_q;
    rd_en      = 1'b0;
    rd_addr    = ptr_q[IDX_W-1:0];
    wr_en      = pend_q;
    wr_addr    = pend_addr_q;
    wr_item    = item_rd_q;
    wr_pri     = pri_rd_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d     = 1'b1;
          item_out_d = '0;
          status_d   = apq_pkg::ST_DONE;
          unique case (operation_i)
            apq_pkg::OP_ADD: begin
              if (cnt_q == DEPTH_C) begin
                status_d = apq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_q[IDX_W-1:0];
                wr_item = item_value_i;
                wr_pri  = priority_req_i;
                cnt_d   = cnt_q + ONE_C;
              end
            end
            apq_pkg::OP_EXTRACT: begin
              if (cnt_q == '0) begin
                status_d = apq_pkg::ST_EMPTY;
              end else begin
                done_d  = 1'b0;
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            apq_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_q != cnt_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + ONE_C;
        end else begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        ptr_d   = CNT_W'(best_idx) + ONE_C;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (ptr_q != cnt_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + ONE_C;
        end else if (!pend_q) begin
          done_d     = 1'b1;
          item_out_d = best_item;
          status_d   = apq_pkg::ST_DONE;
          cnt_d      = cnt_q - ONE_C;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      rvalid_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      done_q   <= done_d;
      rvalid_q <= rd_en && (state_q == S_SCAN);
      pend_q   <= rd_en && (state_q == S_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    item_out_q  <= item_out_d;
    status_q    <= status_d;
    ridx_q      <= rd_addr;
    pend_addr_q <= rd_addr - IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      item_mem[wr_addr] <= wr_item;
      pri_mem[wr_addr]  <= wr_pri;
    end
    if (rd_en) begin
      item_rd_q <= item_mem[rd_addr];
      pri_rd_q  <= pri_mem[rd_addr];
    end
  end

  assign scan_ctl.valid = rvalid_q;
  assign scan_ctl.first = (ridx_q == '0);

  apq_scan #(
    .IDX_W  (IDX_W),
    .ITEM_W (ITEM_WIDTH),
    .PRI_W  (PRIORITY_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .ctl_i       (scan_ctl),
    .idx_i       (ridx_q),
    .pri_i       (pri_rd_q),
    .item_i      (item_rd_q),
    .best_idx_o  (best_idx),
    .best_item_o (best_item)
  );

  assign done_o     = done_q;
  assign item_out_o = item_out_q;
  assign status_o   = status_q;
  assign count_o    = cnt_q;
  assign is_full_o  = (cnt_q == DEPTH_C);
  assign is_empty_o = (cnt_q == '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count above depth");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == apq_pkg::ST_FULL) |-> is_full_o)
    else $error("add dropped while queue not full");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == apq_pkg::ST_EMPTY) |-> is_empty_o && (item_out_o == '0))
    else $error("empty extract reported wrongly");

  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == S_SHIFT) && (pend_addr_q < cnt_q[IDX_W-1:0] || cnt_q == DEPTH_C))
    else $error("tail write outside shift");

  a_extract_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) && (ptr_q == cnt_q) && !pend_q |=> done_o && (state_q == S_IDLE))
    else $error("extract did not finish after shift");

endmodule

`default_nettype wire

[tb/tb_array_priority_queue_max_core.sv]
// Self-checking testbench for the array max priority queue core.
`timescale 1ns / 1ps

module tb_array_priority_queue_max_core;

  localparam int unsigned QDEPTH = apq_pkg::DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned DRAIN_CYCLES = 2 * QDEPTH + 10;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] value;
    logic [15:0] pri;
    int unsigned gap;
  } queue_cmd_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
    logic [4:0]  count;
    logic        full;
    logic        empty;
  } queue_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        start_r = 1'b0;
  logic [1:0]  op_r = apq_pkg::OP_ADD;
  logic [31:0] value_r = '0;
  logic [15:0] pri_r = '0;

  logic        busy;
  logic        done_o;
  logic [31:0] item_out_o;
  logic [1:0]  status_o;
  logic [4:0]  count_o;
  logic        is_full_o;
  logic        is_empty_o;

  queue_cmd_t     cmd_backlog[$];
  queue_outcome_t pending_outcomes[$];
  logic [31:0]    shadow_item[QDEPTH];
  logic [15:0]    shadow_pri[QDEPTH];
  int unsigned    shadow_count = 0;
  int unsigned    gap_left = 0;
  int unsigned    err_cnt = 0;

  array_priority_queue_max_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .start         (start_r),
    .busy          (busy),
    .operation_i   (op_r),
    .item_value_i  (value_r),
    .priority_req_i(pri_r),
    .done_o        (done_o),
    .item_out_o    (item_out_o),
    .status_o      (status_o),
    .count_o       (count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic [31:0] value,
                          input logic [15:0] pri, input int unsigned gap);
    queue_cmd_t c;
    c.op = op;
    c.value = value;
    c.pri = pri;
    c.gap = gap;
    cmd_backlog.push_back(c);
  endtask

  task automatic predict_outcome(input logic [1:0] op, input logic [31:0] value,
                                 input logic [15:0] pri);
    queue_outcome_t o;
    int unsigned best;
    o.value = '0;
    o.status = apq_pkg::ST_DONE;
    case (op)
      apq_pkg::OP_ADD: begin
        if (shadow_count >= QDEPTH) begin
          o.status = apq_pkg::ST_FULL;
        end else begin
          shadow_item[shadow_count] = value;
          shadow_pri[shadow_count] = pri;
          shadow_count++;
        end
      end
      apq_pkg::OP_EXTRACT: begin
        if (shadow_count == 0) begin
          o.status = apq_pkg::ST_EMPTY;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < shadow_count; i++) begin
            if (shadow_pri[i] > shadow_pri[best]) best = i;
          end
          o.value = shadow_item[best];
          for (int unsigned i = best; i + 1 < shadow_count; i++) begin
            shadow_item[i] = shadow_item[i + 1];
            shadow_pri[i] = shadow_pri[i + 1];
          end
          shadow_count--;
        end
      end
      apq_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    o.count = shadow_count[4:0];
    o.full = (shadow_count == QDEPTH);
    o.empty = (shadow_count == 0);
    pending_outcomes.push_back(o);
  endtask

  function automatic logic [15:0] draw_pri();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, 3));
    if (r == 4) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    if (r == 5) return 16'hFFFF - 16'($urandom_range(0, 2));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] draw_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  always @(posedge clk_i) begin : driver
    logic       nxt_start;
    queue_cmd_t c;
    nxt_start = start_r;
    if (rst_n) begin
      if (start_r && !busy) begin
        predict_outcome(op_r, value_r, pri_r);
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          c = cmd_backlog.pop_front();
          op_r <= c.op;
          value_r <= c.value;
          pri_r <= c.pri;
          gap_left = c.gap;
          nxt_start = 1'b1;
        end
      end
    end
    start_r <= nxt_start;
  end

  always @(posedge clk_i) begin : monitor
    queue_outcome_t e;
    if (rst_n && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report("result with no outstanding item");
      end else begin
        e = pending_outcomes.pop_front();
        if (item_out_o !== e.value)
          report($sformatf("item_out %h, want %h", item_out_o, e.value));
        if (status_o !== e.status)
          report($sformatf("status %0d, want %0d", status_o, e.status));
        if (count_o !== e.count)
          report($sformatf("count %0d, want %0d", count_o, e.count));
        if (is_full_o !== e.full)
          report($sformatf("is_full %b, want %b", is_full_o, e.full));
        if (is_empty_o !== e.empty)
          report($sformatf("is_empty %b, want %b", is_empty_o, e.empty));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("array_priority_queue_max_core verification failed");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned burst;
    int unsigned r;
    int unsigned gap;
    logic [1:0]  op;

    push_cmd(apq_pkg::OP_EXTRACT, 32'hDEAD_BEEF, 16'hFFFF, $urandom_range(0, 6));
    push_cmd(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, $urandom_range(0, 6));
    push_cmd(apq_pkg::OP_CLEAR, 32'h0, 16'h0, $urandom_range(0, 6));
    push_cmd(apq_pkg::OP_ADD, 32'h0000_0000, 16'h0000, 0);
    push_cmd(apq_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0);
    push_cmd(apq_pkg::OP_ADD, 32'h5555_5555, 16'hFFFF, $urandom_range(0, 6));
    push_cmd(apq_pkg::OP_ADD, 32'hAAAA_AAAA, 16'h8000, $urandom_range(0, 6));
    for (int i = 0; i < 12; i++) begin
      push_cmd(apq_pkg::OP_ADD, $urandom, 16'($urandom_range(0, 2)), $urandom_range(0, 6));
    end
    push_cmd(apq_pkg::OP_ADD, 32'h1234_5678, 16'hFFFF, $urandom_range(0, 6));
    push_cmd(OP_UNUSED, 32'h0, 16'h0, 0);
    push_cmd(apq_pkg::OP_EXTRACT, 32'h0, 16'h0, 0);
    push_cmd(apq_pkg::OP_EXTRACT, 32'h0, 16'h0, $urandom_range(0, 6));
    push_cmd(apq_pkg::OP_CLEAR, 32'h0, 16'h0, 0);
    push_cmd(apq_pkg::OP_EXTRACT, 32'h0, 16'h0, 0);

    mode = 0;
    burst = 0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        burst = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      case (mode)
        0: op = (r < 70) ? apq_pkg::OP_ADD : (r < 94) ? apq_pkg::OP_EXTRACT :
                (r < 97) ? apq_pkg::OP_CLEAR : OP_UNUSED;
        1: op = (r < 25) ? apq_pkg::OP_ADD : (r < 96) ? apq_pkg::OP_EXTRACT :
                (r < 98) ? apq_pkg::OP_CLEAR : OP_UNUSED;
        default: op = (r < 50) ? apq_pkg::OP_ADD : (r < 95) ? apq_pkg::OP_EXTRACT :
                      (r < 97) ? apq_pkg::OP_CLEAR : OP_UNUSED;
      endcase
      gap = burst ? 0 : $urandom_range(0, 6);
      push_cmd(op, draw_value(), draw_pri(), gap);
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || start_r || pending_outcomes.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_outcomes.size() > 0) report("outstanding results never arrived");
    if (err_cnt == 0) begin
      $display("array_priority_queue_max_core verification clean");
    end else begin
      $display("array_priority_queue_max_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/apq_pkg.sv
hdl/apq_scan.sv
hdl/array_priority_queue_max_core.sv
tb/tb_array_priority_queue_max_core.sv
